@@ design/dual_pulse_sound_generator_assert.svh @@
// assertion macros for the pulse sound generator
`ifndef DUAL_PULSE_SOUND_GENERATOR_ASSERT_SVH
`define DUAL_PULSE_SOUND_GENERATOR_ASSERT_SVH
// implication checked every clock outside reset
`define DPSG_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define DPSG_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

@@ design/dpsg_pkg.sv @@
// shared types, constants and a length table for the pulse sound generator
package dpsg_pkg;
  localparam int CHANNELS_DEF = 2;
  localparam logic [15:0] FRAME_PERIOD_RST = 16'd7458;
  localparam logic [4:0] CLOCK_DIV_RST = 5'd1;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_SNOOP = 2'd3
  } op_t;

  localparam logic [4:0] ADDR_PCM_CTRL = 5'd16;
  localparam logic [4:0] ADDR_PCM_DATA = 5'd17;
  localparam logic [4:0] ADDR_STATUS   = 5'd21;

  localparam logic CFG_FRAME_PERIOD = 1'b0;
  localparam logic CFG_CLOCK_DIV    = 1'b1;

  // classified command from front to back
  typedef struct packed {
    op_t        op;
    logic [4:0] address;
    logic [7:0] data;
    logic [1:0] ch;
    logic [1:0] reg_sel;
    logic       ch_hit;
  } cmd_t;

  function automatic logic [7:0] len_lookup(input logic [4:0] idx);
    logic [7:0] r;
    case (idx)
      5'd0: r = 8'h0A;  5'd1: r = 8'hFE;  5'd2: r = 8'h14;  5'd3: r = 8'h02;
      5'd4: r = 8'h28;  5'd5: r = 8'h04;  5'd6: r = 8'h50;  5'd7: r = 8'h06;
      5'd8: r = 8'hA0;  5'd9: r = 8'h08;  5'd10: r = 8'h3C; 5'd11: r = 8'h0A;
      5'd12: r = 8'h0E; 5'd13: r = 8'h0C; 5'd14: r = 8'h1A; 5'd15: r = 8'h0E;
      5'd16: r = 8'h0C; 5'd17: r = 8'h10; 5'd18: r = 8'h18; 5'd19: r = 8'h12;
      5'd20: r = 8'h30; 5'd21: r = 8'h14; 5'd22: r = 8'h60; 5'd23: r = 8'h16;
      5'd24: r = 8'hC0; 5'd25: r = 8'h18; 5'd26: r = 8'h48; 5'd27: r = 8'h1A;
      5'd28: r = 8'h10; 5'd29: r = 8'h1C; 5'd30: r = 8'h20; default: r = 8'h1E;
    endcase
    return r;
  endfunction
endpackage

@@ design/dpsg_front.sv @@
// front end: accepts words, classifies them and queues commands
module dpsg_front #(
  parameter int CHANNELS = dpsg_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          operation,
  input  logic [4:0]          address,
  input  logic [7:0]          data,
  output logic                cmd_valid,
  input  logic                cmd_take,
  output dpsg_pkg::cmd_t      cmd
);
  localparam int D = dpsg_pkg::QUEUE_DEPTH;
  dpsg_pkg::cmd_t q [D];
  logic       wp, rp;
  logic [1:0] count;
  dpsg_pkg::cmd_t incoming;
  logic push, pop;

  always_comb begin
    incoming.op      = dpsg_pkg::op_t'(operation);
    incoming.address = address;
    incoming.data    = data;
    incoming.ch      = address[3:2];
    incoming.reg_sel = address[1:0];
    incoming.ch_hit  = !address[4] && (32'(address[3:2]) < CHANNELS);
  end

  assign in_stall  = (count == 2'(D));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= incoming;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `include "dual_pulse_sound_generator_assert.svh"
  `DPSG_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= 2'(D))
  `DPSG_ASSERT_NXT(a_push_only, clk, rst, push && !pop, count == $past(count) + 2'd1)
  `DPSG_ASSERT_NXT(a_pop_only, clk, rst, pop && !push, count == $past(count) - 2'd1)
endmodule

@@ design/dpsg_back.sv @@
// back end: channel state, frame divider, pcm and result register
module dpsg_back #(
  parameter int CHANNELS = dpsg_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_take,
  input  dpsg_pkg::cmd_t     cmd,
  input  logic [15:0]        frame_period,
  input  logic [4:0]         clock_divider,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         read_data,
  output logic [3:0]         pulse_a_level,
  output logic [3:0]         pulse_b_level,
  output logic [7:0]         pcm_level,
  output logic               irq
);
  localparam logic [19:0] FRAME_RST = 20'(dpsg_pkg::FRAME_PERIOD_RST);

  logic [7:0]  length_count [CHANNELS];
  logic [3:0]  env_period   [CHANNELS];
  logic [4:0]  env_delay    [CHANNELS];
  logic [3:0]  env_level    [CHANNELS];
  logic [10:0] tone_period  [CHANNELS];
  logic [1:0]  duty_mode    [CHANNELS];
  logic [2:0]  seq_phase    [CHANNELS];
  logic        f_en [CHANNELS], f_halt [CHANNELS], f_start [CHANNELS], f_const [CHANNELS];
  logic [19:0] timer_left   [CHANNELS];
  logic [19:0] tone_reload  [CHANNELS];
  logic [19:0] frame_left, frame_reload;
  logic [7:0]  pcm_value;
  logic        pcm_snoop_mode, pcm_irq_en, pcm_fired;
  logic [4:0]  div_eff;
  logic        go, frame_fire;
  logic [3:0]  lvl [CHANNELS];
  logic [7:0]  status;
  logic [7:0]  read_next;

  assign cmd_take = !out_valid || !out_stall;
  assign go = cmd_valid && cmd_take;
  assign frame_fire = (frame_left <= 20'd1);

  always_comb begin
    if (clock_divider == 5'd0) div_eff = 5'd1;
    else if (clock_divider > 5'd16) div_eff = 5'd16;
    else div_eff = clock_divider;
  end

  // reload values from the current period and divider
  assign frame_reload = 20'(frame_period) * 20'(div_eff);

  always_comb begin
    status = 8'd0;
    for (int c = 0; c < CHANNELS; c++) begin
      status[c] = (length_count[c] != 8'd0);
      lvl[c] = 4'd0;
      if (length_count[c] != 8'd0 && tone_period[c] >= 11'd8) begin
        logic on;
        case (duty_mode[c])
          2'd0: on = (seq_phase[c] < 3'd1);
          2'd1: on = (seq_phase[c] < 3'd2);
          2'd2: on = (seq_phase[c] < 3'd4);
          default: on = (seq_phase[c] >= 3'd2);
        endcase
        if (on) lvl[c] = f_const[c] ? env_period[c] : env_level[c];
      end
    end
  end

  always_comb begin
    read_next = 8'd0;
    if (cmd.op == dpsg_pkg::OP_READ) begin
      if (cmd.address == dpsg_pkg::ADDR_PCM_CTRL) read_next = {pcm_fired, 7'd0};
      else if (cmd.address == dpsg_pkg::ADDR_STATUS) read_next = status;
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
    assign tone_reload[g] = (20'(tone_period[g]) + 20'd1) * 20'(div_eff) * 20'd2;

    always_ff @(posedge clk) begin
      if (rst) begin
        length_count[g] <= 8'd0;
        env_period[g] <= 4'd1;
        env_delay[g] <= 5'd1;
        env_level[g] <= 4'd0;
        tone_period[g] <= 11'd0;
        duty_mode[g] <= 2'd0;
        seq_phase[g] <= 3'd0;
        f_en[g] <= 1'b0; f_halt[g] <= 1'b0; f_start[g] <= 1'b0; f_const[g] <= 1'b0;
        timer_left[g] <= 20'd0;
      end else if (go) begin
        case (cmd.op)
          dpsg_pkg::OP_TICK: begin
            if (frame_fire) begin
              if (length_count[g] != 8'd0 && !f_halt[g])
                length_count[g] <= length_count[g] - 8'd1;
              if (f_start[g]) begin
                f_start[g] <= 1'b0;
                env_delay[g] <= {1'b0, env_period[g]} + 5'd1;
                env_level[g] <= 4'd15;
              end else if (env_delay[g] == 5'd1) begin
                env_delay[g] <= {1'b0, env_period[g]} + 5'd1;
                if (env_level[g] != 4'd0) env_level[g] <= env_level[g] - 4'd1;
                else if (f_halt[g]) env_level[g] <= 4'd15;
              end else begin
                env_delay[g] <= env_delay[g] - 5'd1;
              end
            end
            if (timer_left[g] <= 20'd1) begin
              seq_phase[g] <= seq_phase[g] + 3'd1;
              timer_left[g] <= tone_reload[g];
            end else begin
              timer_left[g] <= timer_left[g] - 20'd1;
            end
          end
          dpsg_pkg::OP_WRITE: begin
            if (cmd.ch_hit && 2'(g) == cmd.ch) begin
              case (cmd.reg_sel)
                2'd0: begin
                  duty_mode[g] <= cmd.data[7:6];
                  f_halt[g] <= cmd.data[5];
                  f_const[g] <= cmd.data[4];
                  env_period[g] <= cmd.data[3:0];
                end
                2'd2: tone_period[g][7:0] <= cmd.data;
                2'd3: begin
                  tone_period[g][10:8] <= cmd.data[2:0];
                  f_start[g] <= 1'b1;
                  seq_phase[g] <= 3'd7;
                  if (f_en[g]) length_count[g] <= dpsg_pkg::len_lookup(cmd.data[7:3]);
                end
                default: ;
              endcase
            end else if (cmd.address == dpsg_pkg::ADDR_STATUS) begin
              f_en[g] <= cmd.data[g];
              if (!cmd.data[g]) length_count[g] <= 8'd0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_left <= FRAME_RST;
      pcm_value <= 8'd0;
      pcm_snoop_mode <= 1'b0;
      pcm_irq_en <= 1'b0;
      pcm_fired <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= go || (out_valid && out_stall);
      if (go) begin
        read_data <= read_next;
        case (cmd.op)
          dpsg_pkg::OP_TICK:
            frame_left <= frame_fire ? frame_reload : frame_left - 20'd1;
          dpsg_pkg::OP_WRITE: begin
            if (cmd.address == dpsg_pkg::ADDR_PCM_CTRL) begin
              pcm_snoop_mode <= cmd.data[0];
              pcm_irq_en <= cmd.data[7];
            end else if (cmd.address == dpsg_pkg::ADDR_PCM_DATA) begin
              if (!pcm_snoop_mode && cmd.data != 8'd0) pcm_value <= cmd.data;
            end
          end
          dpsg_pkg::OP_READ: begin
            if (cmd.address == dpsg_pkg::ADDR_PCM_CTRL) pcm_fired <= 1'b0;
          end
          default: begin
            if (pcm_snoop_mode) begin
              if (cmd.data != 8'd0) pcm_value <= cmd.data;
              else if (pcm_irq_en) pcm_fired <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // levels follow the state, which changes only when a word is taken
  assign pulse_a_level = lvl[0];
  assign pcm_level = pcm_value;
  assign irq = pcm_fired;
  if (CHANNELS > 1) begin : g_b
    assign pulse_b_level = lvl[CHANNELS > 1 ? 1 : 0];
  end else begin : g_nb
    assign pulse_b_level = 4'd0;
  end

  `include "dual_pulse_sound_generator_assert.svh"
  `DPSG_ASSERT_NXT(a_go_valid, clk, rst, go, out_valid)
  `DPSG_ASSERT_NXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(read_data))
  `DPSG_ASSERT_IMP(a_take, clk, rst, out_valid && out_stall, !cmd_take)
endmodule

@@ design/dual_pulse_sound_generator.sv @@
// top level of the two-channel pulse sound generator
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | operation, address, data
//  out     | out_valid / out_stall| read_data, pulse_a_level, pulse_b_level,
//          |                      | pcm_level, irq
//  cfg     | cfg_write            | cfg_index, cfg_data
//
// one word per clock unless the output stalls; path: queue, then back end
// the back end's result register is the only pacing point: it takes a command
// from the two-entry queue whenever its result is taken or empty
// timer and frame reload values are small products formed from current state
// reset is synchronous: channel state, frame divider and pcm state cleared
// a stall on the output fills the queue, then stalls the input
module dual_pulse_sound_generator #(
  parameter int CHANNELS = dpsg_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [4:0]  address,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [3:0]  pulse_a_level,
  output logic [3:0]  pulse_b_level,
  output logic [7:0]  pcm_level,
  output logic        irq,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] frame_period;
  logic [4:0]  clock_divider;
  logic        cmd_valid, cmd_take;
  dpsg_pkg::cmd_t cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period <= dpsg_pkg::FRAME_PERIOD_RST;
      clock_divider <= dpsg_pkg::CLOCK_DIV_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        dpsg_pkg::CFG_FRAME_PERIOD: frame_period <= cfg_data;
        default: clock_divider <= cfg_data[4:0];
      endcase
    end
  end

  dpsg_front #(.CHANNELS(CHANNELS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .operation, .address, .data,
    .cmd_valid, .cmd_take, .cmd
  );

  dpsg_back #(.CHANNELS(CHANNELS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd, .frame_period, .clock_divider,
    .out_valid, .out_stall, .read_data, .pulse_a_level, .pulse_b_level,
    .pcm_level, .irq
  );
endmodule

@@ tb/tb_dual_pulse_sound_generator.sv @@
// testbench for the two-channel pulse sound generator: directed and random words
module tb_dual_pulse_sound_generator;
  localparam int NCH = 2;
  localparam int CYCLE_LIMIT = 400000;

  // result word as seen on the output channel
  typedef struct packed {
    logic [7:0] rdata;
    logic [3:0] lvl_a;
    logic [3:0] lvl_b;
    logic [7:0] pcm;
    logic       irq_bit;
  } snd_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = '0;
  logic [4:0]  address = '0;
  logic [7:0]  data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic [3:0]  pulse_a_level;
  logic [3:0]  pulse_b_level;
  logic [7:0]  pcm_level;
  logic        irq;
  logic        cfg_write = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dual_pulse_sound_generator #(.CHANNELS(NCH)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: a copy of the block's registers and channel state
  logic [15:0] m_frame_period;
  logic [4:0]  m_divider;
  logic [7:0]  m_len [NCH];
  logic [3:0]  m_env_per [NCH];
  logic [4:0]  m_env_dly [NCH];
  logic [3:0]  m_env_lvl [NCH];
  logic [10:0] m_tone [NCH];
  logic [1:0]  m_duty [NCH];
  logic [2:0]  m_phase [NCH];
  logic        m_en [NCH], m_halt [NCH], m_start [NCH], m_const [NCH];
  logic [19:0] m_timer [NCH];
  logic [19:0] m_frame_left;
  logic [7:0]  m_pcm;
  logic        m_read_mode, m_irq_en, m_irq_fired;

  snd_word_t expected_words[$];
  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 0;   // when set, both sides run without idling

  function automatic logic [7:0] length_of(input logic [4:0] i);
    logic [7:0] t [32];
    t = '{8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
          8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
          8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
          8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E};
    return t[i];
  endfunction

  function automatic logic [19:0] eff_divider();
    if (m_divider == 5'd0) return 20'd1;
    if (m_divider > 5'd16) return 20'd16;
    return 20'(m_divider);
  endfunction

  function automatic logic [3:0] level_of(input int c);
    logic [3:0] vol;
    logic on;
    if (m_len[c] == 8'd0 || m_tone[c] < 11'd8) return 4'd0;
    vol = m_const[c] ? m_env_per[c] : m_env_lvl[c];
    case (m_duty[c])
      2'd0: on = m_phase[c] < 3'd1;
      2'd1: on = m_phase[c] < 3'd2;
      2'd2: on = m_phase[c] < 3'd4;
      default: on = m_phase[c] >= 3'd2;
    endcase
    return on ? vol : 4'd0;
  endfunction

  task automatic model_reset();
    m_frame_period = dpsg_pkg::FRAME_PERIOD_RST;
    m_divider = dpsg_pkg::CLOCK_DIV_RST;
    for (int c = 0; c < NCH; c++) begin
      m_len[c] = 8'd0; m_env_per[c] = 4'd1; m_env_dly[c] = 5'd1; m_env_lvl[c] = 4'd0;
      m_tone[c] = 11'd0; m_duty[c] = 2'd0; m_phase[c] = 3'd0; m_timer[c] = 20'd0;
      m_en[c] = 1'b0; m_halt[c] = 1'b0; m_start[c] = 1'b0; m_const[c] = 1'b0;
    end
    m_frame_left = 20'(m_frame_period) * eff_divider();
    m_pcm = 8'd0; m_read_mode = 1'b0; m_irq_en = 1'b0; m_irq_fired = 1'b0;
  endtask

  // envelope and length step on a frame clock
  task automatic frame_step(input int c);
    if (m_len[c] != 8'd0 && !m_halt[c]) m_len[c]--;
    if (m_start[c]) begin
      m_start[c] = 1'b0;
      m_env_dly[c] = 5'(m_env_per[c]) + 5'd1;
      m_env_lvl[c] = 4'd15;
    end else begin
      m_env_dly[c] = m_env_dly[c] - 5'd1;
      if (m_env_dly[c] == 5'd0) begin
        m_env_dly[c] = 5'(m_env_per[c]) + 5'd1;
        if (m_env_lvl[c] != 4'd0) m_env_lvl[c]--;
        else if (m_halt[c]) m_env_lvl[c] = 4'd15;
      end
    end
  endtask

  // advance the predictor by one accepted word and queue the expected result
  task automatic predict_word(input logic [1:0] op, input logic [4:0] a,
                              input logic [7:0] v);
    snd_word_t w;
    int c;
    w = '0;
    case (dpsg_pkg::op_t'(op))
      dpsg_pkg::OP_TICK: begin
        if (m_frame_left <= 20'd1) begin
          for (int k = 0; k < NCH; k++) frame_step(k);
          m_frame_left = 20'(m_frame_period) * eff_divider();
        end else m_frame_left--;
        for (int k = 0; k < NCH; k++) begin
          if (m_timer[k] <= 20'd1) begin
            m_phase[k]++;
            m_timer[k] = (20'(m_tone[k]) * 20'd2 + 20'd2) * eff_divider();
          end else m_timer[k]--;
        end
      end
      dpsg_pkg::OP_WRITE: begin
        if (a < 5'd16) begin
          c = int'(a >> 2);
          if (c < NCH) begin
            case (a[1:0])
              2'd0: begin
                m_duty[c] = v[7:6]; m_halt[c] = v[5]; m_const[c] = v[4];
                m_env_per[c] = v[3:0];
              end
              2'd2: m_tone[c][7:0] = v;
              2'd3: begin
                m_tone[c][10:8] = v[2:0];
                m_start[c] = 1'b1; m_phase[c] = 3'd7;
                if (m_en[c]) m_len[c] = length_of(v[7:3]);
              end
              default: ;
            endcase
          end
        end else if (a == dpsg_pkg::ADDR_PCM_CTRL) begin
          m_read_mode = v[0]; m_irq_en = v[7];
        end else if (a == dpsg_pkg::ADDR_PCM_DATA) begin
          if (!m_read_mode && v != 8'd0) m_pcm = v;
        end else if (a == dpsg_pkg::ADDR_STATUS) begin
          for (int k = 0; k < NCH; k++) begin
            m_en[k] = v[k];
            if (!v[k]) m_len[k] = 8'd0;
          end
        end
      end
      dpsg_pkg::OP_READ: begin
        if (a == dpsg_pkg::ADDR_PCM_CTRL) begin
          w.rdata = m_irq_fired ? 8'h80 : 8'h00;
          m_irq_fired = 1'b0;
        end else if (a == dpsg_pkg::ADDR_STATUS) begin
          for (int k = 0; k < NCH; k++) if (m_len[k] != 8'd0) w.rdata[k] = 1'b1;
        end
      end
      default: begin
        if (m_read_mode) begin
          if (v != 8'd0) m_pcm = v;
          else if (m_irq_en) m_irq_fired = 1'b1;
        end
      end
    endcase
    w.lvl_a = level_of(0);
    w.lvl_b = level_of(1);
    w.pcm = m_pcm;
    w.irq_bit = m_irq_fired;
    expected_words.push_back(w);
  endtask

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 19);
  endfunction

  // send one word, with random gaps ahead of it; valid stays up until the next
  // word, a gap ahead of the next word, or a drain
  task automatic send_word(input logic [1:0] op, input logic [4:0] a,
                           input logic [7:0] v);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op; address <= a; data <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(op, a, v);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // registers change only while the block is empty
  task automatic write_cfg(input logic [0:0] idx, input logic [15:0] v);
    drain();
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == dpsg_pkg::CFG_FRAME_PERIOD) m_frame_period = v;
    else m_divider = v[4:0];
  endtask

  // receiver: random stalls, every accepted result checked
  always @(negedge clk) out_stall <= idle_now();

  always @(posedge clk) begin
    snd_word_t got, exp_w;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      got = '{read_data, pulse_a_level, pulse_b_level, pcm_level, irq};
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (got.rdata !== exp_w.rdata)
          $display("%0t: read_data expected %h actual %h", $time, exp_w.rdata, got.rdata);
        if (got.lvl_a !== exp_w.lvl_a)
          $display("%0t: pulse_a_level expected %h actual %h", $time, exp_w.lvl_a, got.lvl_a);
        if (got.lvl_b !== exp_w.lvl_b)
          $display("%0t: pulse_b_level expected %h actual %h", $time, exp_w.lvl_b, got.lvl_b);
        if (got.pcm !== exp_w.pcm)
          $display("%0t: pcm_level expected %h actual %h", $time, exp_w.pcm, got.pcm);
        if (got.irq_bit !== exp_w.irq_bit)
          $display("%0t: irq expected %b actual %b", $time, exp_w.irq_bit, got.irq_bit);
        if (got !== exp_w) errors++;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("dual_pulse_sound_generator verification failed");
      $finish;
    end
  end

  task automatic ticks(input int n);
    repeat (n) send_word(dpsg_pkg::OP_TICK, 5'($urandom), 8'($urandom));
  endtask

  // set channel 0 up with a short period so its level toggles quickly, channel 1 with the longest
  task automatic test_channel_setup();
    send_word(dpsg_pkg::OP_WRITE, dpsg_pkg::ADDR_STATUS, 8'h03);
    send_word(dpsg_pkg::OP_WRITE, 5'd0, 8'hBF);          // duty 2, halt, constant 15
    send_word(dpsg_pkg::OP_WRITE, 5'd2, 8'h08);
    send_word(dpsg_pkg::OP_WRITE, 5'd3, 8'h08);          // length index 1
    send_word(dpsg_pkg::OP_WRITE, 5'd4, 8'hC2);          // duty 3, envelope decay
    send_word(dpsg_pkg::OP_WRITE, 5'd6, 8'hFF);
    send_word(dpsg_pkg::OP_WRITE, 5'd7, 8'hFF);          // longest period high
    send_word(dpsg_pkg::OP_WRITE, 5'd1, 8'hFF);          // no-effect register
    send_word(dpsg_pkg::OP_WRITE, 5'd12, 8'hFF);         // channel past the last one
    send_word(dpsg_pkg::OP_READ, dpsg_pkg::ADDR_STATUS, 8'h00);
    ticks(8);
  endtask

  // pcm data writes, read mode snoops and the irq flag clear on read
  task automatic test_pcm();
    send_word(dpsg_pkg::OP_WRITE, dpsg_pkg::ADDR_PCM_DATA, 8'h00); // zero is ignored
    send_word(dpsg_pkg::OP_WRITE, dpsg_pkg::ADDR_PCM_DATA, 8'hFF);
    send_word(dpsg_pkg::OP_SNOOP, 5'd0, 8'h12);          // ignored outside read mode
    send_word(dpsg_pkg::OP_WRITE, dpsg_pkg::ADDR_PCM_CTRL, 8'h81);
    send_word(dpsg_pkg::OP_WRITE, dpsg_pkg::ADDR_PCM_DATA, 8'h33); // ignored in read mode
    send_word(dpsg_pkg::OP_SNOOP, 5'd31, 8'h5A);
    send_word(dpsg_pkg::OP_SNOOP, 5'd0, 8'h00);          // fires irq
    send_word(dpsg_pkg::OP_WRITE, dpsg_pkg::ADDR_PCM_CTRL, 8'h01); // irq stays set
    send_word(dpsg_pkg::OP_READ, dpsg_pkg::ADDR_PCM_CTRL, 8'h00);
    send_word(dpsg_pkg::OP_READ, dpsg_pkg::ADDR_PCM_CTRL, 8'h00);
    send_word(dpsg_pkg::OP_READ, 5'd31, 8'h00);          // unused address
    send_word(dpsg_pkg::OP_WRITE, 5'd31, 8'hFF);
  endtask

  // random traffic: mostly ticks, with writes steering the channels
  task automatic test_random(input int n, input bit calm);
    logic [1:0] op;
    logic [4:0] a;
    logic [7:0] v;
    quiet = calm;
    repeat (n) begin
      a = 5'($urandom); v = 8'($urandom);
      case ($urandom_range(9))
        0, 1: begin
          op = dpsg_pkg::OP_WRITE;
          case ($urandom_range(5))
            0: a = dpsg_pkg::ADDR_STATUS;
            1: a = dpsg_pkg::ADDR_PCM_CTRL;
            2: a = dpsg_pkg::ADDR_PCM_DATA;
            3: a = {3'($urandom_range(1)), 2'($urandom_range(3))};
            4: begin
              a = {3'($urandom_range(1)), 2'd2};
              v = 8'($urandom_range(7, 40));
            end
            default: ;
          endcase
        end
        2: begin
          op = dpsg_pkg::OP_READ;
          a = $urandom_range(1) ? dpsg_pkg::ADDR_STATUS
                                : ($urandom_range(3) ? dpsg_pkg::ADDR_PCM_CTRL : a);
        end
        3: begin op = dpsg_pkg::OP_SNOOP; if ($urandom_range(2) == 0) v = 8'd0; end
        default: op = dpsg_pkg::OP_TICK;
      endcase
      send_word(op, a, v);
    end
    quiet = 0;
  endtask

  // configuration extremes, some of which make frame clocks frequent
  task automatic test_config_sweep();
    write_cfg(dpsg_pkg::CFG_FRAME_PERIOD, 16'd3);
    write_cfg(dpsg_pkg::CFG_CLOCK_DIV, 16'd1);
    test_random(120, 0);
    write_cfg(dpsg_pkg::CFG_FRAME_PERIOD, 16'd1);
    write_cfg(dpsg_pkg::CFG_CLOCK_DIV, 16'd16);
    test_random(80, 1);
    write_cfg(dpsg_pkg::CFG_FRAME_PERIOD, 16'd0);
    write_cfg(dpsg_pkg::CFG_CLOCK_DIV, 16'd0);
    test_random(70, 0);
    drain();                                   // sender holds off until all results are in
    write_cfg(dpsg_pkg::CFG_FRAME_PERIOD, 16'hFFFF);
    write_cfg(dpsg_pkg::CFG_CLOCK_DIV, 16'd31);
    test_random(60, 0);
    write_cfg(dpsg_pkg::CFG_FRAME_PERIOD, 16'd5);
    write_cfg(dpsg_pkg::CFG_CLOCK_DIV, 16'd2);
    test_random(90, 0);
  endtask

  initial begin
    model_reset();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_channel_setup();
    test_pcm();
    test_config_sweep();
    drain();
    repeat (10) @(negedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("dual_pulse_sound_generator verification clean");
    end else begin
      $display("dual_pulse_sound_generator verification failed");
    end
    $finish;
  end
endmodule

@@ dual_pulse_sound_generator.f @@
+incdir+design
design/dpsg_pkg.sv
design/dpsg_front.sv
design/dpsg_back.sv
design/dual_pulse_sound_generator.sv
tb/tb_dual_pulse_sound_generator.sv
